[design/lcd4_pkg.sv]
// ----------------------------------------------------------------------------
// lcd4_pkg: shared types and constants for the 4-bit character LCD block
// Request codes, queue entry layout, strobe layout and the power-up table.
// ----------------------------------------------------------------------------
`default_nettype none

package lcd4_pkg;

  // Request codes on in_cmd
  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_INSTR  = 3'd1;
  localparam logic [2:0] CMD_DATA   = 3'd2;
  localparam logic [2:0] CMD_CURSOR = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // Configuration register indexes
  localparam logic CFG_ENABLE_PULSE  = 1'b0;
  localparam logic CFG_CYCLES_PER_MS = 1'b1;

  // Queue entry kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_INIT = 1'b1;

  // Fixed command bytes
  localparam logic [7:0] LCD_SET_DDRAM  = 8'h80;
  localparam logic [7:0] LCD_ROW1_BASE  = 8'h40;
  localparam logic [7:0] LCD_BLANK_CMD  = 8'h01;
  localparam logic [2:0] WAIT_CURSOR_MS = 3'd1;
  localparam logic [2:0] WAIT_CLEAR_MS  = 3'd2;

  // Power-up run length
  localparam int unsigned INIT_STROBES = 15;
  localparam logic [3:0]  INIT_LAST    = 4'(INIT_STROBES - 1);

  // One request as queued between front and back
  typedef struct packed {
    logic       kind;       // byte pair or power-up run
    logic       rs;         // register select for a byte pair
    logic [7:0] byte_val;   // byte for a byte pair
    logic [2:0] after_ms;   // wait after the low nibble
  } entry_t;

  // One strobe as handed out
  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic [5:0] before_ms;
    logic [2:0] after_ms;
    logic       last;
  } strobe_t;

  // Power-up sequence: three 0x3 nibbles, then 0x02 0x08 0x0F 0x01 0x06 0x02
  function automatic strobe_t init_strobe(input logic [3:0] step);
    strobe_t s;
    s = '0;
    unique case (step)
      4'd0:  begin s.nibble = 4'h3; s.before_ms = 6'd40; s.after_ms = 3'd5; end
      4'd1:  begin s.nibble = 4'h3; s.after_ms = 3'd1; end
      4'd2:  begin s.nibble = 4'h3; s.after_ms = 3'd1; end
      4'd3:  begin s.nibble = 4'h0; end
      4'd4:  begin s.nibble = 4'h2; s.after_ms = 3'd1; end
      4'd5:  begin s.nibble = 4'h0; end
      4'd6:  begin s.nibble = 4'h8; s.after_ms = 3'd1; end
      4'd7:  begin s.nibble = 4'h0; end
      4'd8:  begin s.nibble = 4'hF; s.after_ms = 3'd1; end
      4'd9:  begin s.nibble = 4'h0; end
      4'd10: begin s.nibble = 4'h1; s.after_ms = 3'd2; end
      4'd11: begin s.nibble = 4'h0; end
      4'd12: begin s.nibble = 4'h6; s.after_ms = 3'd1; end
      4'd13: begin s.nibble = 4'h0; end
      4'd14: begin s.nibble = 4'h2; s.after_ms = 3'd2; end
      default: s = '0;
    endcase
    s.last = (step == INIT_LAST);
    return s;
  endfunction

endpackage

`default_nettype wire

[design/lcd4_front.sv]
// ----------------------------------------------------------------------------
// lcd4_front: request decoder
// Turns each incoming beat into one queue entry, or drops it when it
// produces no strobes (unknown code, cursor on rows 2 and 3).
// ----------------------------------------------------------------------------
`default_nettype none

module lcd4_front (
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [2:0]    in_cmd,
  input  wire logic [7:0]    in_byte_value,
  input  wire logic [5:0]    in_column,
  input  wire logic [1:0]    in_row,
  output logic               push,
  output lcd4_pkg::entry_t   push_entry,
  input  wire logic          q_ready
);
  import lcd4_pkg::*;

  logic       keep;
  logic [7:0] row1_addr;

  // Second row starts at DDRAM 0x40; column is at most 63 so no carry out
  assign row1_addr = LCD_ROW1_BASE + {2'b00, in_column};

  // Classify the request
  always_comb begin
    keep       = 1'b1;
    push_entry = '0;
    unique case (in_cmd)
      CMD_INIT: begin
        push_entry.kind = KIND_INIT;
      end
      CMD_INSTR: begin
        push_entry.kind     = KIND_BYTE;
        push_entry.byte_val = in_byte_value;
      end
      CMD_DATA: begin
        push_entry.kind     = KIND_BYTE;
        push_entry.rs       = 1'b1;
        push_entry.byte_val = in_byte_value;
      end
      CMD_CURSOR: begin
        push_entry.kind     = KIND_BYTE;
        push_entry.after_ms = WAIT_CURSOR_MS;
        priority if (in_row == 2'd0) begin
          push_entry.byte_val = LCD_SET_DDRAM | {2'b00, in_column};
        end else if (in_row == 2'd1) begin
          push_entry.byte_val = LCD_SET_DDRAM | row1_addr;
        end else begin
          keep = 1'b0;
        end
      end
      CMD_CLEAR: begin
        push_entry.kind     = KIND_BYTE;
        push_entry.byte_val = LCD_BLANK_CMD;
        push_entry.after_ms = WAIT_CLEAR_MS;
      end
      default: keep = 1'b0;
    endcase
  end

  // A beat is taken whenever the queue has room; dropped beats never enter it
  assign in_ready = q_ready;
  assign push     = in_valid & q_ready & keep;

endmodule

`default_nettype wire

[design/lcd4_queue.sv]
// ----------------------------------------------------------------------------
// lcd4_queue: request queue
// Small FIFO between decoder and strobe sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd4_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire lcd4_pkg::entry_t push_entry,
  output logic                  q_ready,
  input  wire logic             pop,
  output lcd4_pkg::entry_t      pop_entry,
  output logic                  q_valid
);
  import lcd4_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t        mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign q_ready   = (count_r != CW'(DEPTH));
  assign q_valid   = (count_r != '0);
  assign pop_entry = mem_r[rd_ptr_r];
  assign do_push   = push & q_ready;
  assign do_pop    = pop & q_valid;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

[design/lcd4_back.sv]
// ----------------------------------------------------------------------------
// lcd4_back: strobe sequencer
// Expands one queued request into its nibble strobes, holds each for the
// enable pulse time and hands it out through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd4_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [15:0]      pulse_cycles,
  input  wire logic             q_valid,
  input  wire lcd4_pkg::entry_t q_entry,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output lcd4_pkg::strobe_t     out_strobe
);
  import lcd4_pkg::*;

  logic        cur_valid_r, cur_valid_nxt;
  entry_t      cur_r, cur_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  strobe_t     out_r, out_nxt;

  strobe_t     strobe;
  logic        pulse_done;
  logic        out_free;
  logic        fire;

  // Current strobe of the request in hand
  always_comb begin
    if (cur_r.kind == KIND_INIT) begin
      strobe = init_strobe(step_r);
    end else begin
      strobe           = '0;
      strobe.rs        = cur_r.rs;
      strobe.nibble    = (step_r == 4'd0) ? cur_r.byte_val[7:4] : cur_r.byte_val[3:0];
      strobe.after_ms  = (step_r == 4'd0) ? 3'd0 : cur_r.after_ms;
      strobe.last      = (step_r != 4'd0);
    end
  end

  // Enable pulse has run its length
  assign pulse_done = ({1'b0, cnt_r} + 17'd1) >= {1'b0, pulse_cycles};
  assign out_free   = !out_valid_r || out_ready;
  assign fire       = cur_valid_r && pulse_done && out_free;
  assign pop        = q_valid && (!cur_valid_r || (fire && strobe.last));

  // Sequencer
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    priority if (pop) begin
      cur_valid_nxt = 1'b1;
      cur_nxt       = q_entry;
      step_nxt      = '0;
      cnt_nxt       = '0;
    end else if (fire) begin
      cur_valid_nxt = !strobe.last;
      step_nxt      = step_r + 4'd1;
      cnt_nxt       = '0;
    end else if (cur_valid_r && !pulse_done) begin
      cnt_nxt = cnt_r + 16'd1;
    end
  end

  // Output register: one strobe waits here while the next pulse runs
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      out_nxt       = strobe;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_strobe = out_r;

endmodule

`default_nettype wire

[design/char_lcd_4bit_interface.sv]
// ----------------------------------------------------------------------------
// char_lcd_4bit_interface: character LCD front end for a 4-bit bus
// Decoder, request queue and strobe sequencer behind valid/ready channels.
// ----------------------------------------------------------------------------
// Each request beat becomes a run of nibble strobes on the out_ channel:
// two for a command, data, cursor or clear request, fifteen for initialise,
// none for an unknown code or a cursor request on rows 2 and 3. Every strobe
// is held back by the enable pulse counter in the sequencer until the
// programmed enable pulse length has run since the previous strobe or the
// taking of its request, and it also waits while the output register is full.
// Requests are taken one per cycle while the two-entry queue has room.
// The millisecond waits are reported in each strobe's wait fields and are
// timed downstream; a write to cycles_per_millisecond is taken and has no
// effect on the strobes.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_4bit_interface #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // request channel
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [2:0]   in_cmd,
  input  wire logic [7:0]   in_byte_value,
  input  wire logic [5:0]   in_column,
  input  wire logic [1:0]   in_row,
  // strobe channel
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              out_register_select,
  output logic [3:0]        out_nibble,
  output logic [5:0]        out_wait_before_ms,
  output logic [2:0]        out_wait_after_ms,
  output logic              out_last_strobe,
  // configuration writes
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [19:0]  cfg_data
);
  import lcd4_pkg::*;

  logic [15:0] pulse_r;
  logic        push, pop, q_ready, q_valid;
  entry_t      push_entry, pop_entry;
  strobe_t     strobe;

  // Enable pulse length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r <= 16'd1000;
    end else if (cfg_we && (cfg_index == CFG_ENABLE_PULSE)) begin
      pulse_r <= cfg_data[15:0];
    end
  end

  lcd4_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_byte_value (in_byte_value),
    .in_column     (in_column),
    .in_row        (in_row),
    .push          (push),
    .push_entry    (push_entry),
    .q_ready       (q_ready)
  );

  lcd4_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_valid    (q_valid)
  );

  lcd4_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pulse_cycles (pulse_r),
    .q_valid      (q_valid),
    .q_entry      (pop_entry),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_strobe   (strobe)
  );

  assign out_register_select = strobe.rs;
  assign out_nibble          = strobe.nibble;
  assign out_wait_before_ms  = strobe.before_ms;
  assign out_wait_after_ms   = strobe.after_ms;
  assign out_last_strobe     = strobe.last;

endmodule

`default_nettype wire

[tb/tb_char_lcd_4bit_interface.sv]
// ----------------------------------------------------------------------------
// tb_char_lcd_4bit_interface: self-checking bench for the 4-bit LCD front end
// Requests are fed through a queue-driven sender with random gaps. Strobes are
// taken by a receiver that stalls at random and once holds off for a long
// stretch. Every strobe is checked field by field against a predicted run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_char_lcd_4bit_interface;
  import lcd4_pkg::*;

  // Unused request codes, all ignored by the block
  localparam logic [2:0] CMD_BAD_LO = 3'd5;
  localparam logic [2:0] CMD_BAD_HI = 3'd7;

  localparam int unsigned QUIET_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned PRINT_CAP   = 30;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] byte_value;
    logic [5:0] column;
    logic [1:0] row;
  } lcd_req_t;

  typedef struct {
    lcd_req_t    req;
    int unsigned gap;
  } req_slot_t;

  typedef strobe_t strobe_q_t[$];

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [2:0]  in_cmd        = '0;
  logic [7:0]  in_byte_value = '0;
  logic [5:0]  in_column     = '0;
  logic [1:0]  in_row        = '0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic        out_register_select;
  logic [3:0]  out_nibble;
  logic [5:0]  out_wait_before_ms;
  logic [2:0]  out_wait_after_ms;
  logic        out_last_strobe;
  logic        cfg_we        = 1'b0;
  logic        cfg_index     = CFG_ENABLE_PULSE;
  logic [19:0] cfg_data      = '0;

  req_slot_t   pending_reqs[$];
  strobe_t     expected_strobes[$];

  // shadow of the configuration
  int unsigned pulse_shadow = 1000;
  int unsigned ms_shadow    = 100000;

  int unsigned fault_count     = 0;
  int unsigned reqs_taken      = 0;
  int unsigned strobes_checked = 0;
  int unsigned reg_writes      = 0;
  int unsigned idle_left       = 0;
  int unsigned stall_left      = 0;
  int unsigned calm_left       = 0;
  int unsigned hold_left       = 0;
  int unsigned quiet_cycles    = 0;
  logic        hold_arm        = 1'b0;
  logic        hold_done       = 1'b0;

  char_lcd_4bit_interface uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_byte_value       (in_byte_value),
    .in_column           (in_column),
    .in_row              (in_row),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_register_select (out_register_select),
    .out_nibble          (out_nibble),
    .out_wait_before_ms  (out_wait_before_ms),
    .out_wait_after_ms   (out_wait_after_ms),
    .out_last_strobe     (out_last_strobe),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic strobe_t mk_strobe(input logic rs, input logic [3:0] nib,
                                        input logic [5:0] wait_pre,
                                        input logic [2:0] after, input logic last);
    strobe_t s;
    s.rs        = rs;
    s.nibble    = nib;
    s.before_ms = wait_pre;
    s.after_ms  = after;
    s.last      = last;
    return s;
  endfunction

  // Strobe run caused by one request; bytes go high nibble first
  function automatic strobe_q_t strobe_run(input lcd_req_t r);
    strobe_q_t  run;
    logic [7:0] seq_byte  [6];
    logic [2:0] seq_after [6];
    int         nbytes;
    logic       rs;
    nbytes = 0;
    rs     = 1'b0;
    case (r.cmd)
      CMD_INIT: begin
        run.push_back(mk_strobe(1'b0, 4'h3, 6'd40, 3'd5, 1'b0));
        run.push_back(mk_strobe(1'b0, 4'h3, 6'd0, 3'd1, 1'b0));
        run.push_back(mk_strobe(1'b0, 4'h3, 6'd0, 3'd1, 1'b0));
        seq_byte  = '{8'h02, 8'h08, 8'h0F, 8'h01, 8'h06, 8'h02};
        seq_after = '{3'd1, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2};
        nbytes    = 6;
      end
      CMD_INSTR, CMD_DATA: begin
        rs           = (r.cmd == CMD_DATA);
        seq_byte[0]  = r.byte_value;
        seq_after[0] = 3'd0;
        nbytes       = 1;
      end
      CMD_CURSOR: begin
        // rows 2 and 3 do nothing; all six column bits go into the address
        if (r.row == 2'd0) begin
          seq_byte[0] = LCD_SET_DDRAM | {2'b00, r.column};
          nbytes      = 1;
        end else if (r.row == 2'd1) begin
          seq_byte[0] = LCD_SET_DDRAM | (LCD_ROW1_BASE + {2'b00, r.column});
          nbytes      = 1;
        end
        seq_after[0] = WAIT_CURSOR_MS;
      end
      CMD_CLEAR: begin
        seq_byte[0]  = LCD_BLANK_CMD;
        seq_after[0] = WAIT_CLEAR_MS;
        nbytes       = 1;
      end
      default: ;
    endcase
    for (int i = 0; i < nbytes; i++) begin
      run.push_back(mk_strobe(rs, seq_byte[i][7:4], 6'd0, 3'd0, 1'b0));
      run.push_back(mk_strobe(rs, seq_byte[i][3:0], 6'd0, seq_after[i],
                              i == nbytes - 1));
    end
    return run;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    else if (p < 88) return $urandom_range(1, 3);
    else if (p < 97) return $urandom_range(4, 20);
    else return $urandom_range(40, 200);
  endfunction

  function automatic lcd_req_t mk_req(input logic [2:0] cmd, input logic [7:0] b,
                                      input logic [5:0] col, input logic [1:0] row);
    lcd_req_t r;
    r.cmd        = cmd;
    r.byte_value = b;
    r.column     = col;
    r.row        = row;
    return r;
  endfunction

  function automatic lcd_req_t random_request();
    int unsigned p;
    logic [2:0]  cmd;
    logic [5:0]  col;
    logic [1:0]  row;
    p   = $urandom_range(0, 99);
    col = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(40, 63))
                                      : 6'($urandom_range(0, 39));
    row = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                      : 2'($urandom_range(0, 1));
    if (p < 6) cmd = CMD_INIT;
    else if (p < 28) cmd = CMD_INSTR;
    else if (p < 58) cmd = CMD_DATA;
    else if (p < 84) cmd = CMD_CURSOR;
    else if (p < 93) cmd = CMD_CLEAR;
    else cmd = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
    return mk_req(cmd, 8'($urandom), col, row);
  endfunction

  task automatic queue_req(input lcd_req_t r, input bit calm);
    req_slot_t s;
    s.req = r;
    s.gap = calm ? 0 : pick_gap();
    pending_reqs.push_back(s);
  endtask

  // random requests until the given number of them have caused strobes
  task automatic queue_random(input int unsigned want);
    lcd_req_t    r;
    strobe_q_t   run;
    int unsigned produced;
    int unsigned calm;
    produced = 0;
    calm     = 0;
    while (produced < want) begin
      if (calm == 0 && $urandom_range(0, 15) == 0) calm = $urandom_range(8, 25);
      r   = random_request();
      run = strobe_run(r);
      queue_req(r, calm != 0);
      if (calm != 0) calm--;
      if (run.size() != 0) produced++;
    end
  endtask

  task automatic write_reg(input logic idx, input logic [19:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == CFG_ENABLE_PULSE) pulse_shadow = (value[15:0] == 0) ? 1 : value[15:0];
    else ms_shadow = value;
    reg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // all beats taken and all strobes in, then let a dropped request clear
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || expected_strobes.size() != 0)
      @(negedge clk);
    repeat (2 * pulse_shadow + 16) @(negedge clk);
  endtask

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Request sender: one beat at a time from the pending queue
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    req_slot_t slot;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      idle_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (idle_left != 0) begin
        in_valid  <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pending_reqs.size() != 0) begin
        slot = pending_reqs.pop_front();
        in_valid      <= 1'b1;
        in_cmd        <= slot.req.cmd;
        in_byte_value <= slot.req.byte_value;
        in_column     <= slot.req.column;
        in_row        <= slot.req.row;
        idle_left     <= slot.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Strobe receiver: random stalls, calm stretches, one long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      calm_left  <= 0;
      hold_left  <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (calm_left != 0) calm_left <= calm_left - 1;
      else if ($urandom_range(0, 19) == 0) calm_left <= $urandom_range(50, 300);
      else stall_left <= pick_gap();
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each request beat, check each strobe beat
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    strobe_q_t run;
    strobe_t   want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        run = strobe_run(mk_req(in_cmd, in_byte_value, in_column, in_row));
        foreach (run[i]) expected_strobes.push_back(run[i]);
        reqs_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_strobes.size() == 0) begin
          report_fault($sformatf("unexpected strobe, nibble %h rs %b",
                                 out_nibble, out_register_select));
        end else begin
          want = expected_strobes.pop_front();
          strobes_checked++;
          if (out_register_select !== want.rs)
            report_fault($sformatf("register_select %b, want %b",
                                   out_register_select, want.rs));
          if (out_nibble !== want.nibble)
            report_fault($sformatf("nibble %h, want %h", out_nibble, want.nibble));
          if (out_wait_before_ms !== want.before_ms)
            report_fault($sformatf("wait_before_ms %0d, want %0d",
                                   out_wait_before_ms, want.before_ms));
          if (out_wait_after_ms !== want.after_ms)
            report_fault($sformatf("wait_after_ms %0d, want %0d",
                                   out_wait_after_ms, want.after_ms));
          if (out_last_strobe !== want.last)
            report_fault($sformatf("last_strobe %b, want %b",
                                   out_last_strobe, want.last));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any beat on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d strobes outstanding",
                 QUIET_LIMIT, expected_strobes.size());
        $display("tb_char_lcd_4bit_interface: errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed set at reset settings
    queue_req(mk_req(CMD_INIT, 8'h00, 6'd0, 2'd0), 1'b0);
    queue_req(mk_req(CMD_INSTR, 8'h00, 6'd63, 2'd3), 1'b0);
    queue_req(mk_req(CMD_INSTR, 8'hFF, 6'd0, 2'd0), 1'b0);
    queue_req(mk_req(CMD_DATA, 8'h00, 6'd21, 2'd1), 1'b0);
    queue_req(mk_req(CMD_DATA, 8'hFF, 6'd42, 2'd2), 1'b1);
    queue_req(mk_req(CMD_DATA, 8'hA5, 6'd0, 2'd0), 1'b1);
    queue_req(mk_req(CMD_DATA, 8'h5A, 6'd0, 2'd0), 1'b0);
    queue_req(mk_req(CMD_CURSOR, 8'hFF, 6'd0, 2'd0), 1'b0);
    queue_req(mk_req(CMD_CURSOR, 8'h00, 6'd39, 2'd0), 1'b0);
    queue_req(mk_req(CMD_CURSOR, 8'hFF, 6'd0, 2'd1), 1'b0);
    queue_req(mk_req(CMD_CURSOR, 8'h00, 6'd39, 2'd1), 1'b0);
    // columns past the display edge go straight into the address
    queue_req(mk_req(CMD_CURSOR, 8'h00, 6'd63, 2'd0), 1'b0);
    queue_req(mk_req(CMD_CURSOR, 8'h00, 6'd63, 2'd1), 1'b0);
    // rows 2 and 3 are dropped
    queue_req(mk_req(CMD_CURSOR, 8'h00, 6'd5, 2'd2), 1'b0);
    queue_req(mk_req(CMD_CURSOR, 8'hFF, 6'd63, 2'd3), 1'b0);
    queue_req(mk_req(CMD_CLEAR, 8'hFF, 6'd63, 2'd3), 1'b0);
    // unused codes are dropped
    queue_req(mk_req(CMD_BAD_LO, 8'h12, 6'd1, 2'd0), 1'b0);
    queue_req(mk_req(CMD_BAD_LO + 3'd1, 8'h34, 6'd2, 2'd1), 1'b0);
    queue_req(mk_req(CMD_BAD_HI, 8'hFF, 6'd63, 2'd3), 1'b0);
    queue_req(mk_req(CMD_INIT, 8'hFF, 6'd63, 2'd3), 1'b0);
    wait_idle();

    // shortest pulse, with the long receiver hold-off
    write_reg(CFG_ENABLE_PULSE, 20'd1);
    write_reg(CFG_CYCLES_PER_MS, 20'd1);
    queue_random(70);
    @(posedge clk);
    hold_arm <= 1'b1;
    wait_idle();

    // longest pulse, one request only
    write_reg(CFG_ENABLE_PULSE, 20'd65535);
    write_reg(CFG_CYCLES_PER_MS, 20'd1000000);
    queue_req(mk_req(CMD_DATA, 8'($urandom), 6'($urandom), 2'($urandom)), 1'b0);
    wait_idle();

    // short random pulse; junk above the 16-bit register
    write_reg(CFG_ENABLE_PULSE, {4'($urandom), 16'($urandom_range(1, 16))});
    write_reg(CFG_CYCLES_PER_MS, 20'($urandom_range(1, 1000000)));
    queue_random(70);
    wait_idle();

    write_reg(CFG_CYCLES_PER_MS, 20'($urandom_range(1, 1000000)));
    write_reg(CFG_ENABLE_PULSE, 20'($urandom_range(2, 40)));
    queue_random(70);
    wait_idle();

    $display("run covered %0d requests and %0d checked strobes over %0d register writes",
             reqs_taken, strobes_checked, reg_writes);
    $display("pulse lengths 1 to 65535, with a %0d-cycle output hold-off; %0d faults",
             HOLD_CYCLES, fault_count);
    if (fault_count == 0) begin
      $display("tb_char_lcd_4bit_interface: clean");
    end else begin
      $display("tb_char_lcd_4bit_interface: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
design/lcd4_pkg.sv
design/lcd4_front.sv
design/lcd4_queue.sv
design/lcd4_back.sv
design/char_lcd_4bit_interface.sv
tb/tb_char_lcd_4bit_interface.sv
